// ===== rtl/u16u8_pkg.sv =====
// shared types and constants for the utf-16 to utf-8 encoder
// no dependencies
package u16u8_pkg;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MALFORMED  = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned IDX_W   = $clog2(MAX_RES);
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  // code unit range limits
  localparam logic [15:0] ASCII_MAX = 16'h007F;
  localparam logic [15:0] TWO_MAX   = 16'h07FF;
  localparam logic [15:0] SURR_LO   = 16'hD800;
  localparam logic [15:0] LOW_LO    = 16'hDC00;
  localparam logic [15:0] SURR_HI   = 16'hDFFF;

  // utf-8 lead and continuation markers
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  localparam logic [20:0] SUPP_BASE = 21'h010000;

  // all results caused by one accepted unit
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    logic [MAX_RES-1:0][7:0]   bytes;
    logic [MAX_RES-1:0][1:0]   stat;
  } desc_t;

endpackage

// ===== rtl/u16u8_front.sv =====
// front end: classifies each code unit, tracks the held high surrogate
// and builds the descriptor of its results; depends on u16u8_pkg
module u16u8_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [15:0]        code_unit,
  input  logic               end_of_input,
  output logic               push,
  output u16u8_pkg::desc_t   desc
);
  import u16u8_pkg::*;

  logic        high_pending_r, high_pending_nxt;
  logic [9:0]  high_bits_r, high_bits_nxt;
  logic        is_high, is_low;
  logic [20:0] cp;
  logic [CNT_W-1:0] n;

  assign is_high = (code_unit >= SURR_LO) && (code_unit < LOW_LO);
  assign is_low  = (code_unit >= LOW_LO) && (code_unit <= SURR_HI);
  assign cp      = SUPP_BASE + {1'b0, high_bits_r, code_unit[9:0]};

  always_comb begin
    n                = '0;
    desc             = '0;
    high_pending_nxt = high_pending_r;
    high_bits_nxt    = high_bits_r;
    if (high_pending_r && is_low) begin
      desc.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
      desc.bytes[1] = CONT | {2'd0, cp[17:12]};
      desc.bytes[2] = CONT | {2'd0, cp[11:6]};
      desc.bytes[3] = CONT | {2'd0, cp[5:0]};
      desc.stat     = {MAX_RES{ST_OK}};
      n             = CNT_W'(4);
      high_pending_nxt = 1'b0;
      high_bits_nxt    = '0;
    end else begin
      if (high_pending_r) begin
        desc.stat[n[IDX_W-1:0]] = ST_MALFORMED;
        n = n + CNT_W'(1);
        high_pending_nxt = 1'b0;
        high_bits_nxt    = '0;
      end
      priority if (code_unit <= ASCII_MAX) begin
        desc.bytes[n[IDX_W-1:0]] = code_unit[7:0];
        n = n + CNT_W'(1);
      end else if (code_unit <= TWO_MAX) begin
        desc.bytes[n[IDX_W-1:0]] = LEAD2 | {3'd0, code_unit[10:6]};
        n = n + CNT_W'(1);
        desc.bytes[n[IDX_W-1:0]] = CONT | {2'd0, code_unit[5:0]};
        n = n + CNT_W'(1);
      end else if (is_high) begin
        high_pending_nxt = 1'b1;
        high_bits_nxt    = code_unit[9:0];
      end else if (is_low) begin
        desc.stat[n[IDX_W-1:0]] = ST_MALFORMED;
        n = n + CNT_W'(1);
      end else begin
        desc.bytes[n[IDX_W-1:0]] = LEAD3 | {4'd0, code_unit[15:12]};
        n = n + CNT_W'(1);
        desc.bytes[n[IDX_W-1:0]] = CONT | {2'd0, code_unit[11:6]};
        n = n + CNT_W'(1);
        desc.bytes[n[IDX_W-1:0]] = CONT | {2'd0, code_unit[5:0]};
        n = n + CNT_W'(1);
      end
    end
    // high surrogate left dangling at end of message
    if (end_of_input && high_pending_nxt) begin
      desc.stat[n[IDX_W-1:0]] = ST_INCOMPLETE;
      n = n + CNT_W'(1);
      high_pending_nxt = 1'b0;
      high_bits_nxt    = '0;
    end
    desc.cnt = n;
  end

  assign push = accept && (n != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_pending_r <= 1'b0;
      high_bits_r    <= '0;
    end else if (accept) begin
      high_pending_r <= high_pending_nxt;
      high_bits_r    <= high_bits_nxt;
    end
  end

endmodule

// ===== rtl/u16u8_fifo.sv =====
// two-entry descriptor queue between front and back end
// depends on u16u8_pkg
module u16u8_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u16u8_pkg::desc_t   wr_desc,
  input  logic               pop,
  output u16u8_pkg::desc_t   rd_desc,
  output logic               not_empty,
  output logic               full
);
  import u16u8_pkg::*;

  desc_t      mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign rd_desc   = mem[rd_ptr_r];
  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/u16u8_back.sv =====
// back end: walks each descriptor one result per beat into the output register
// depends on u16u8_pkg
module u16u8_back (
  input  logic               clk,
  input  logic               rst_n,
  input  u16u8_pkg::desc_t   head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_status,
  output logic               out_last_of_run
);
  import u16u8_pkg::*;

  logic             out_valid_r;
  logic [7:0]       byte_r;
  logic [1:0]       status_r;
  logic             last_r;
  logic [IDX_W-1:0] idx_r;
  logic             load, take, is_last;

  assign load    = !out_valid_r || out_ready;
  assign take    = load && head_valid;
  assign is_last = ({1'b0, idx_r} == (head.cnt - CNT_W'(1)));
  assign pop     = take && is_last;

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_status      = status_r;
  assign out_last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) out_valid_r <= head_valid;
      if (take) idx_r <= is_last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r   <= head.bytes[idx_r];
      status_r <= head.stat[idx_r];
      last_r   <= is_last;
    end
  end

endmodule

// ===== rtl/utf16_to_utf8_encoder.sv =====
// utf-16 to utf-8 encoder top level; uses u16u8_pkg, u16u8_front, u16u8_fifo, u16u8_back
// a unit's first result beat passes the descriptor queue, then the output register
// throughput: one unit per cycle while each gives one beat and out_ready is high; the
//   output port moves one beat per cycle while out_ready is high, one beat per result of
//   a unit, and in_ready drops only while the two-entry descriptor queue is full
// reset: synchronous active-low rst_n clears the held surrogate, queue and output valid
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last_of_run
);
  import u16u8_pkg::*;

  desc_t front_desc, head_desc;
  logic  accept, push, pop, head_valid, q_full;

  // the front takes a unit whenever the queue has room, even while the
  // output register is stalled
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // classify the unit and expand it into a result descriptor
  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .code_unit    (in_code_unit),
    .end_of_input (in_end_of_input),
    .push         (push),
    .desc         (front_desc)
  );

  // units that give no result (held high surrogate) never enter the queue
  u16u8_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_desc   (front_desc),
    .pop       (pop),
    .rd_desc   (head_desc),
    .not_empty (head_valid),
    .full      (q_full)
  );

  // serialize each descriptor, one beat per cycle while out_ready is high
  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head_desc),
    .head_valid      (head_valid),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

endmodule
